### rtl/core/csg_pkg.sv
// shared types and constants for the color similarity grouper
package csg_pkg;

  localparam int MAX_COLORS = 64;
  localparam int IDX_W      = $clog2(MAX_COLORS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int THR_W      = 18;
  localparam int CFG_W      = 18;

  // luma weights, sum of weights is 1000
  localparam int W_RED   = 299;
  localparam int W_GREEN = 587;
  localparam int W_BLUE  = 114;
  localparam int WSUM_W  = 18;

  // floor(x / 1000) = floor((x >> 3) / 125), the last by reciprocal multiply
  localparam int DIV_SHIFT = 22;
  localparam int DIV_MULT  = ((1 << DIV_SHIFT) + 124) / 125;
  localparam int DIV_M_W   = 16;
  localparam int PROD_W    = (WSUM_W - 3) + DIV_M_W;

  // configuration register indexes
  localparam logic [0:0] REG_ENABLE = 1'b0;
  localparam logic [0:0] REG_THRESH = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LUMA,
    ST_SLOAD,
    ST_SLATCH,
    ST_SSCAN,
    ST_SWRITE,
    ST_GLOAD,
    ST_GLATCH,
    ST_GSCAN,
    ST_OREAD,
    ST_OLOAD,
    ST_OHOLD
  } state_t;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [23:0]      rgb_t;

  // squared rgb distance
  function automatic logic [THR_W-1:0] dist_sq(input rgb_t a, input rgb_t b);
    logic [7:0]  dr, dg, db;
    logic [15:0] sr, sg, sb;
    dr = (a[23:16] > b[23:16]) ? a[23:16] - b[23:16] : b[23:16] - a[23:16];
    dg = (a[15:8] > b[15:8]) ? a[15:8] - b[15:8] : b[15:8] - a[15:8];
    db = (a[7:0] > b[7:0]) ? a[7:0] - b[7:0] : b[7:0] - a[7:0];
    sr = dr * dr;
    sg = dg * dg;
    sb = db * db;
    return {2'b00, sr} + {2'b00, sg} + {2'b00, sb};
  endfunction

endpackage

### rtl/core/color_similarity_grouper.sv
// color similarity grouper: collects a color set, sorts by luma, groups greedily when enabled
// load: a stored color passes through the luma divide step before the next color is taken
// after the final color of n: sort makes one luma memory read per pair,
// grouping one color memory read per compare,
// then each result is read, loaded and held while stalled; input stalls until the last result
// reset clears control state and the set count; color, luma and order memories are not cleared
module color_similarity_grouper (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [0:0]                  cfg_index,
  input  logic [csg_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  red,
  input  logic [7:0]                  green,
  input  logic [7:0]                  blue,
  input  logic                        final_entry,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [csg_pkg::IDX_W-1:0]   entry_index,
  output logic [csg_pkg::IDX_W-1:0]   leader_index,
  output logic                        is_leader,
  output logic                        run_end
);

  csg_pkg::state_t state, state_next;

  // memories
  csg_pkg::rgb_t color_mem  [csg_pkg::MAX_COLORS];
  logic [7:0]    luma_mem   [csg_pkg::MAX_COLORS];
  csg_pkg::idx_t order_mem  [csg_pkg::MAX_COLORS];
  csg_pkg::rgb_t scolor_mem [csg_pkg::MAX_COLORS];
  csg_pkg::idx_t lead_mem   [csg_pkg::MAX_COLORS];

  csg_pkg::rgb_t color_q, scolor_q;
  logic [7:0]    luma_q;
  csg_pkg::idx_t order_q, lead_q;
  csg_pkg::idx_t rd_addr;

  // control and datapath registers
  logic                        group_en;
  logic [csg_pkg::THR_W-1:0]   thr;
  logic [csg_pkg::CNT_W-1:0]   count;
  logic                        fin_pend;
  csg_pkg::idx_t               wr_idx;
  logic [csg_pkg::WSUM_W-1:0]  wsum;
  csg_pkg::idx_t               n_last;
  csg_pkg::idx_t               e_idx, pos, jj, rank;
  logic [7:0]                  luma_e;
  csg_pkg::rgb_t               color_e, lead_color;
  csg_pkg::idx_t               lead_idx;
  logic [csg_pkg::MAX_COLORS-1:0] done_flags;

  logic                        accept, store_ok;
  logic [csg_pkg::PROD_W-1:0]  prod;
  logic                        sort_lt, hit, grp_go;
  csg_pkg::idx_t               n_last_acc;

  assign accept   = in_valid && !in_stall;
  assign store_ok = (count < csg_pkg::CNT_W'(csg_pkg::MAX_COLORS));
  assign prod     = csg_pkg::PROD_W'(wsum[csg_pkg::WSUM_W-1:3])
                  * csg_pkg::PROD_W'(csg_pkg::DIV_MULT);
  assign sort_lt  = (luma_q < luma_e) || ((luma_q == luma_e) && (jj < e_idx));
  assign hit      = !done_flags[jj] && (csg_pkg::dist_sq(lead_color, scolor_q) <= thr);
  assign grp_go   = group_en && (n_last != '0);
  // index of the last color once this item is counted
  assign n_last_acc = store_ok ? count[csg_pkg::IDX_W-1:0]
                               : csg_pkg::IDX_W'(csg_pkg::MAX_COLORS - 1);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      csg_pkg::ST_IDLE: begin
        if (accept) begin
          if (store_ok) state_next = csg_pkg::ST_LUMA;
          else if (final_entry) state_next = csg_pkg::ST_SLOAD;
        end
      end
      csg_pkg::ST_LUMA:   state_next = fin_pend ? csg_pkg::ST_SLOAD : csg_pkg::ST_IDLE;
      csg_pkg::ST_SLOAD:  state_next = csg_pkg::ST_SLATCH;
      csg_pkg::ST_SLATCH: state_next = csg_pkg::ST_SSCAN;
      csg_pkg::ST_SSCAN:  if (jj == n_last) state_next = csg_pkg::ST_SWRITE;
      csg_pkg::ST_SWRITE: begin
        if (e_idx != n_last) state_next = csg_pkg::ST_SLOAD;
        else state_next = grp_go ? csg_pkg::ST_GLOAD : csg_pkg::ST_OREAD;
      end
      csg_pkg::ST_GLOAD: begin
        if (pos == n_last) state_next = csg_pkg::ST_OREAD;
        else if (!done_flags[pos]) state_next = csg_pkg::ST_GLATCH;
      end
      csg_pkg::ST_GLATCH: state_next = csg_pkg::ST_GSCAN;
      csg_pkg::ST_GSCAN:  if (jj == n_last) state_next = csg_pkg::ST_GLOAD;
      csg_pkg::ST_OREAD:  state_next = csg_pkg::ST_OLOAD;
      csg_pkg::ST_OLOAD:  state_next = csg_pkg::ST_OHOLD;
      csg_pkg::ST_OHOLD: begin
        if (!out_stall) state_next = (pos == n_last) ? csg_pkg::ST_IDLE : csg_pkg::ST_OREAD;
      end
      default:   state_next = csg_pkg::ST_IDLE;
    endcase
  end

  // handshake and read address
  always_comb begin
    in_stall  = (state != csg_pkg::ST_IDLE);
    out_valid = (state == csg_pkg::ST_OHOLD);
    rd_addr   = pos;
    unique case (state)
      csg_pkg::ST_SLOAD:  rd_addr = e_idx;
      csg_pkg::ST_SLATCH: rd_addr = '0;
      csg_pkg::ST_SSCAN:  rd_addr = jj + 1'b1;
      csg_pkg::ST_GLATCH: rd_addr = pos + 1'b1;
      csg_pkg::ST_GSCAN:  rd_addr = jj + 1'b1;
      default:   rd_addr = pos;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= csg_pkg::ST_IDLE;
    else state <= state_next;
  end

  // memory reads
  always_ff @(posedge clk) begin
    color_q  <= color_mem[rd_addr];
    luma_q   <= luma_mem[rd_addr];
    order_q  <= order_mem[rd_addr];
    scolor_q <= scolor_mem[rd_addr];
    lead_q   <= lead_mem[rd_addr];
  end

  // memory writes
  always_ff @(posedge clk) begin
    if (accept && store_ok) color_mem[count[csg_pkg::IDX_W-1:0]] <= {red, green, blue};
    if (state == csg_pkg::ST_LUMA) luma_mem[wr_idx] <= prod[csg_pkg::DIV_SHIFT +: 8];
    if (state == csg_pkg::ST_SWRITE) begin
      order_mem[rank]  <= e_idx;
      scolor_mem[rank] <= color_e;
    end
    if ((state == csg_pkg::ST_GSCAN) && hit) lead_mem[jj] <= lead_idx;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      group_en <= 1'b1;
      thr      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        csg_pkg::REG_ENABLE: group_en <= cfg_data[0];
        csg_pkg::REG_THRESH: thr      <= cfg_data[csg_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // control counters and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      done_flags <= '0;
      fin_pend   <= 1'b0;
    end else begin
      unique case (state)
        csg_pkg::ST_IDLE: begin
          if (accept) begin
            fin_pend <= final_entry;
            n_last   <= n_last_acc;
            e_idx    <= '0;
            if (store_ok) count <= count + 1'b1;
          end
        end
        csg_pkg::ST_SSCAN: begin
          rank <= rank + csg_pkg::IDX_W'(sort_lt);
          jj   <= jj + 1'b1;
        end
        csg_pkg::ST_SLATCH: begin
          jj   <= '0;
          rank <= '0;
        end
        csg_pkg::ST_SWRITE: begin
          e_idx <= e_idx + 1'b1;
          pos   <= '0;
        end
        csg_pkg::ST_GLOAD: begin
          if (pos == n_last) pos <= '0;
          else if (done_flags[pos]) pos <= pos + 1'b1;
        end
        csg_pkg::ST_GLATCH: jj <= pos + 1'b1;
        csg_pkg::ST_GSCAN: begin
          if (hit) done_flags[jj] <= 1'b1;
          jj <= jj + 1'b1;
          if (jj == n_last) pos <= pos + 1'b1;
        end
        csg_pkg::ST_OHOLD: begin
          if (!out_stall) begin
            pos <= pos + 1'b1;
            if (pos == n_last) begin
              count      <= '0;
              done_flags <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      wr_idx <= count[csg_pkg::IDX_W-1:0];
      wsum   <= csg_pkg::WSUM_W'(csg_pkg::W_RED * red)
              + csg_pkg::WSUM_W'(csg_pkg::W_GREEN * green)
              + csg_pkg::WSUM_W'(csg_pkg::W_BLUE * blue);
    end
    if (state == csg_pkg::ST_SLATCH) begin
      luma_e  <= luma_q;
      color_e <= color_q;
    end
    if (state == csg_pkg::ST_GLATCH) begin
      lead_color <= scolor_q;
      lead_idx   <= order_q;
    end
    if (state == csg_pkg::ST_OLOAD) begin
      entry_index  <= order_q;
      leader_index <= done_flags[pos] ? lead_q : order_q;
      is_leader    <= !done_flags[pos];
      run_end      <= (pos == n_last);
    end
  end

endmodule

### rtl/core/csg_checker.sv
// port checker for the color similarity grouper, bound to the top level
module csg_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [csg_pkg::IDX_W-1:0] entry_index,
  input logic [csg_pkg::IDX_W-1:0] leader_index,
  input logic                      is_leader,
  input logic                      run_end
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(entry_index)
      && $stable(leader_index) && $stable(is_leader) && $stable(run_end))
    else $error("stalled item changed");

  // no new color taken while results are pending
  a_no_in: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input open during output");

  // leader flag agrees with the indexes
  a_leader: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_leader == (entry_index == leader_index)))
    else $error("leader flag mismatch");

  // reset leaves no result showing
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("item valid after reset");

endmodule

bind color_similarity_grouper csg_checker u_csg_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall), .out_valid(out_valid),
  .out_stall(out_stall), .entry_index(entry_index), .leader_index(leader_index),
  .is_leader(is_leader), .run_end(run_end)
);

### dv/tb_top.sv
// self-checking testbench for the color similarity grouper
`timescale 1ns / 100ps

// expected group results and comparison against the block's output
class leader_scoreboard;
  typedef struct packed {
    logic [5:0] entry;
    logic [5:0] leader;
    logic       lead;
    logic       last;
  } grp_t;

  bit          enabled;
  int unsigned thresh;
  logic [23:0] colors[$];
  grp_t        pending[$];
  int          errors;

  function new();
    enabled = 1;
    thresh = 0;
    errors = 0;
  endfunction

  function void set_reg(bit idx, int unsigned val);
    if (idx == csg_pkg::REG_ENABLE) enabled = val[0];
    else thresh = val & 18'h3ffff;
  endfunction

  function int unsigned luma(logic [23:0] c);
    return (299 * c[23:16] + 587 * c[15:8] + 114 * c[7:0]) / 1000;
  endfunction

  function int unsigned color_dist(logic [23:0] a, logic [23:0] b);
    int unsigned s;
    int d;
    s = 0;
    for (int k = 0; k < 3; k++) begin
      d = int'(a[k*8 +: 8]) - int'(b[k*8 +: 8]);
      s += d * d;
    end
    return s;
  endfunction

  // note an accepted input color
  function void note_color(logic [7:0] r, g, b, bit fin);
    int order[$];
    int lead[$];
    bit taken[$];
    int n, j;
    grp_t e;
    if (colors.size() < csg_pkg::MAX_COLORS) colors.insert(colors.size(), {r, g, b});
    if (!fin) return;
    n = colors.size();
    // stable sort by luma
    for (int i = 0; i < n; i++) begin
      j = order.size();
      while (j > 0 && luma(colors[order[j-1]]) > luma(colors[i])) j--;
      order.insert(j, i);
    end
    for (int i = 0; i < n; i++) begin
      lead.insert(lead.size(), order[i]);
      taken.insert(taken.size(), 1'b0);
    end
    // greedy leader grouping
    if (enabled && n > 1)
      for (int i = 0; i < n; i++) begin
        if (taken[i]) continue;
        taken[i] = 1;
        for (int k = i + 1; k < n; k++)
          if (!taken[k] && color_dist(colors[order[i]], colors[order[k]]) <= thresh) begin
            taken[k] = 1;
            lead[k] = order[i];
          end
      end
    for (int i = 0; i < n; i++) begin
      e.entry = 6'(order[i]);
      e.leader = 6'(lead[i]);
      e.lead = (lead[i] == order[i]);
      e.last = (i == n - 1);
      pending.insert(pending.size(), e);
    end
    colors.delete();
  endfunction

  // compare one result with the oldest expectation
  function void check_result(logic [5:0] ei, li, bit il, re);
    grp_t e;
    if (pending.size() == 0) begin
      $error("unexpected result entry_index=%0d", ei);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (ei !== e.entry) begin
      $error("entry_index exp %0d got %0d", e.entry, ei); errors++;
    end
    if (li !== e.leader) begin
      $error("leader_index exp %0d got %0d", e.leader, li); errors++;
    end
    if (il !== e.lead) begin
      $error("is_leader exp %0d got %0d", e.lead, il); errors++;
    end
    if (re !== e.last) begin
      $error("run_end exp %0d got %0d", e.last, re); errors++;
    end
  endfunction
endclass

module tb_top;

  localparam int STALL_LIMIT = 40000;

  logic clk, rst;
  logic cfg_we;
  logic [0:0] cfg_index;
  logic [csg_pkg::CFG_W-1:0] cfg_data;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [7:0] red, green, blue;
  logic final_entry;
  logic [csg_pkg::IDX_W-1:0] entry_index, leader_index;
  logic is_leader, run_end;

  int send_idle_pct, recv_stall_pct;
  int idle_cycles;
  leader_scoreboard sb;
  logic [23:0] palette[8];

  color_similarity_grouper dut (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // output side: random stall and result checking
  always @(posedge clk) begin
    if (rst) out_stall <= 0;
    else begin
      if (out_valid && !out_stall)
        sb.check_result(entry_index, leader_index, is_leader, run_end);
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // watchdog on cycles with no accepted item
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("[color_similarity_grouper] ERROR");
      $finish;
    end
  end

  task automatic write_reg(bit idx, int unsigned val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= csg_pkg::CFG_W'(val);
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  // send one color, random idle gaps before it
  task automatic send_color(logic [7:0] r, g, b, bit fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    red <= r;
    green <= g;
    blue <= b;
    final_entry <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_color(r, g, b, fin);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // a set of n colors, either fully random or clustered near palette entries
  task automatic send_set(int n, bit clustered);
    logic [23:0] c;
    int k;
    for (int i = 0; i < n; i++) begin
      if (clustered) begin
        c = palette[$urandom_range(7)];
        for (k = 0; k < 3; k++) c[k*8 +: 8] = 8'(c[k*8 +: 8] ^ $urandom_range(7));
      end else c = 24'($urandom);
      send_color(c[23:16], c[15:8], c[7:0], i == n - 1);
    end
  endtask

  initial begin
    sb = new();
    rst = 1;
    cfg_we = 0; cfg_index = 0; cfg_data = 0;
    in_valid = 0; red = 0; green = 0; blue = 0; final_entry = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes, single color, luma ties, disabled grouping
    send_color(8'hff, 8'hff, 8'hff, 1);
    send_color(8'h00, 8'h00, 8'h00, 0);
    send_color(8'hff, 8'h00, 8'h00, 0);
    send_color(8'h00, 8'hff, 8'h00, 0);
    send_color(8'h00, 8'h00, 8'hff, 0);
    send_color(8'h00, 8'h00, 8'h00, 0);
    send_color(8'hff, 8'hff, 8'hff, 1);
    drain();
    write_reg(csg_pkg::REG_THRESH, 195075);
    send_color(8'h00, 8'h00, 8'h00, 0);
    send_color(8'hff, 8'hff, 8'hff, 0);
    send_color(8'h80, 8'h80, 8'h80, 1);
    drain();
    write_reg(csg_pkg::REG_THRESH, 18'h3ffff);
    send_color(8'h10, 8'h20, 8'h30, 0);
    send_color(8'h10, 8'h20, 8'h31, 1);
    drain();
    write_reg(csg_pkg::REG_ENABLE, 0);
    send_color(8'h55, 8'haa, 8'h55, 0);
    send_color(8'h55, 8'haa, 8'h56, 1);
    drain();
    write_reg(csg_pkg::REG_ENABLE, 1);
    write_reg(csg_pkg::REG_THRESH, 1);
    send_color(8'h40, 8'h40, 8'h40, 0);
    send_color(8'h40, 8'h40, 8'h41, 0);
    send_color(8'h40, 8'h41, 8'h41, 1);
    drain();

    // full store plus dropped colors, once
    write_reg(csg_pkg::REG_THRESH, 3000);
    for (int i = 0; i < 8; i++) palette[i] = 24'($urandom);
    send_set(csg_pkg::MAX_COLORS + 2, 1);
    drain();

    // random sets over idling phases and register settings
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 77 : 13) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 77 : 13) : 0;
      write_reg(csg_pkg::REG_ENABLE, $urandom_range(9) != 0);
      case (ph)
        0: write_reg(csg_pkg::REG_THRESH, 0);
        1: write_reg(csg_pkg::REG_THRESH, $urandom_range(2000));
        2: write_reg(csg_pkg::REG_THRESH, $urandom_range(40000));
        default: write_reg(csg_pkg::REG_THRESH, $urandom_range(262143));
      endcase
      for (int i = 0; i < 8; i++) palette[i] = 24'($urandom);
      for (int s = 0; s < 3; s++) send_set($urandom_range(1, 7), $urandom_range(3) != 0);
      // sender waits until every result has come
      drain();
    end

    if (sb.errors == 0) $display("[color_similarity_grouper] OK");
    else $display("[color_similarity_grouper] ERROR");
    $finish;
  end
endmodule
